[rtl/brx_pkg.sv]
// ----------------------------------------------------------------------------
// brx_pkg: shared definitions for the barcode frame receiver
// Link control characters, parser states, event and reply codes.
// ----------------------------------------------------------------------------
package brx_pkg;

  // largest payload a command frame may carry
  localparam int unsigned MAX_PAYLOAD = 256;

  // link control characters
  localparam logic [7:0] CH_STX      = 8'h02;
  localparam logic [7:0] CH_ETX      = 8'h03;
  localparam logic [7:0] CH_ACK      = 8'h06;
  localparam logic [7:0] CH_NACK     = 8'h15;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CMD_NO_DATA = 8'h80;

  // largest legal byte count, in the width of the data counter
  localparam logic [8:0] MAX_PAYLOAD_CNT = 9'(MAX_PAYLOAD);

  // parser states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_CODE = 3'd1,
    ST_CMD  = 3'd2,
    ST_LEN  = 3'd3,
    ST_DATA = 3'd4,
    ST_ETX  = 3'd5,
    ST_CHK  = 3'd6
  } state_t;

  // result events
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CHAR  = 3'd1,
    EV_END   = 3'd2,
    EV_OK    = 3'd3,
    EV_BAD   = 3'd4,
    EV_PACK  = 3'd5,
    EV_PNACK = 3'd6
  } event_t;

  // reply requests toward the transmitter
  typedef enum logic [1:0] {
    RP_NONE = 2'd0,
    RP_ACK  = 2'd1,
    RP_NACK = 2'd2
  } reply_t;

endpackage

[rtl/barcode_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// barcode_frame_receiver_core: receive framer for a barcode reader link
// Streams barcode characters, parses STX/ETX command frames with an XOR
// checksum and reports partner ACK/NACK bytes, one result per byte.
// ----------------------------------------------------------------------------
// Each accepted byte's result is loaded into the output register in the cycle after it is taken.
// Throughput: one byte per cycle; the only limit is the single output register,
// so a byte is taken whenever that register is empty or being read the same cycle.
// Reset: rst (synchronous, active high) returns the parser to idle, clears the
// code count, command, data counter, checksum and frame-good flag, and empties
// the output register.
module barcode_frame_receiver_core (
  input  logic       clk,
  input  logic       rst,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [7:0] code_char,
  output logic [7:0] code_length,
  output logic [7:0] frame_command,
  output logic [1:0] reply
);
  import brx_pkg::*;

  // parser state
  state_t     parse_state, parse_state_next;
  logic [7:0] code_count, code_count_next;
  logic [7:0] command_byte, command_byte_next;
  logic [8:0] data_remaining, data_remaining_next;
  logic [7:0] running_xor, running_xor_next;
  logic       etx_seen_ok, etx_seen_ok_next;

  // result of the current byte
  event_t     ev_next;
  reply_t     rp_next;
  logic [7:0] ch_next, len_next, cmd_next;

  logic       accept;
  logic       is_eol;
  logic [8:0] data_dec;

  // a new request fits when the output register is free or draining
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign data_dec = (data_remaining != 9'd0) ? data_remaining - 9'd1 : data_remaining;

  // next state and parser registers
  always_comb begin
    parse_state_next    = parse_state;
    code_count_next     = code_count;
    command_byte_next   = command_byte;
    data_remaining_next = data_remaining;
    running_xor_next    = running_xor;
    etx_seen_ok_next    = etx_seen_ok;
    case (parse_state)
      ST_CODE: begin
        if (is_eol) begin
          code_count_next  = 8'd0;
          parse_state_next = ST_IDLE;
        end else if (code_count != 8'hFF) begin
          code_count_next = code_count + 8'd1;
        end
      end
      ST_CMD: begin
        command_byte_next   = rx_byte;
        running_xor_next    = running_xor ^ rx_byte;
        data_remaining_next = 9'd0;
        parse_state_next    = ((rx_byte & CMD_NO_DATA) != 8'd0) ? ST_ETX : ST_LEN;
      end
      ST_LEN: begin
        data_remaining_next = {1'b0, rx_byte} + 9'd1;
        if (({1'b0, rx_byte} + 9'd1) > MAX_PAYLOAD_CNT) begin
          etx_seen_ok_next = 1'b0;
        end
        parse_state_next = ST_DATA;
      end
      ST_DATA: begin
        running_xor_next    = running_xor ^ rx_byte;
        data_remaining_next = data_dec;
        if (data_dec == 9'd0) begin
          parse_state_next = ST_ETX;
        end
      end
      ST_ETX: begin
        etx_seen_ok_next = etx_seen_ok && (rx_byte == CH_ETX);
        parse_state_next = ST_CHK;
      end
      ST_CHK: begin
        parse_state_next = ST_IDLE;
      end
      default: begin
        // idle, and the unused code
        parse_state_next = ST_IDLE;
        if (rx_byte == CH_STX) begin
          running_xor_next    = CH_STX ^ CH_ETX;
          etx_seen_ok_next    = 1'b1;
          data_remaining_next = 9'd0;
          parse_state_next    = ST_CMD;
        end else if (rx_byte == CH_ACK || rx_byte == CH_NACK) begin
          parse_state_next = ST_IDLE;
        end else if (is_eol) begin
          code_count_next = 8'd0;
        end else begin
          code_count_next  = 8'd1;
          parse_state_next = ST_CODE;
        end
      end
    endcase
  end

  // result fields
  always_comb begin
    ev_next  = EV_NONE;
    rp_next  = RP_NONE;
    ch_next  = 8'd0;
    len_next = 8'd0;
    cmd_next = 8'd0;
    case (parse_state)
      ST_CODE: begin
        if (is_eol) begin
          ev_next  = EV_END;
          len_next = code_count;
          rp_next  = RP_ACK;
        end else begin
          ev_next = EV_CHAR;
          ch_next = rx_byte;
        end
      end
      ST_CMD, ST_LEN, ST_DATA, ST_ETX: begin
        ev_next = EV_NONE;
      end
      ST_CHK: begin
        if (etx_seen_ok && (running_xor == rx_byte)) begin
          ev_next  = EV_OK;
          cmd_next = command_byte;
          rp_next  = RP_ACK;
        end else begin
          ev_next = EV_BAD;
          rp_next = RP_NACK;
        end
      end
      default: begin
        if (rx_byte == CH_STX) begin
          ev_next = EV_NONE;
        end else if (rx_byte == CH_ACK) begin
          ev_next = EV_PACK;
        end else if (rx_byte == CH_NACK) begin
          ev_next = EV_PNACK;
        end else if (!is_eol) begin
          ev_next = EV_CHAR;
          ch_next = rx_byte;
        end
      end
    endcase
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state    <= ST_IDLE;
      code_count     <= 8'd0;
      command_byte   <= 8'd0;
      data_remaining <= 9'd0;
      running_xor    <= 8'd0;
      etx_seen_ok    <= 1'b0;
    end else if (accept) begin
      parse_state    <= parse_state_next;
      code_count     <= code_count_next;
      command_byte   <= command_byte_next;
      data_remaining <= data_remaining_next;
      running_xor    <= running_xor_next;
      etx_seen_ok    <= etx_seen_ok_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      event_res     <= ev_next;
      code_char     <= ch_next;
      code_length   <= len_next;
      frame_command <= cmd_next;
      reply         <= rp_next;
    end
  end

  // a taken byte always leaves a result waiting
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte produced no result");

  // inside a barcode at least one character has been counted
  a_code_count: assert property (@(posedge clk) disable iff (rst)
    (parse_state == ST_CODE) |-> (code_count != 8'd0))
    else $error("code state with zero count");

  // the data phase always has bytes left to take
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    (parse_state == ST_DATA) |-> (data_remaining != 9'd0))
    else $error("data state with nothing remaining");

  // end of code and good frames ask for ACK, bad frames for NACK
  a_reply_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res == EV_END || event_res == EV_OK)) |-> (reply == RP_ACK))
    else $error("missing ACK reply");

  a_reply_bad: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_BAD) |-> (reply == RP_NACK))
    else $error("missing NACK reply");

endmodule
